// ===== src/bpa_pkg.sv =====
// Shared constants and codes for the buddy page allocator.
package bpa_pkg;

  localparam int PAGES_DEF = 32768;
  localparam int RANKS_DEF = 16;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_PRANK = 2'd2;
  localparam logic [1:0] OP_COUNT = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  localparam logic REG_PAGE_COUNT = 1'b0;

endpackage

// ===== src/bpa_ram.sv =====
// Single write port, single registered read port RAM.
module bpa_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 32768,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/buddy_page_allocator_top.sv =====
// Buddy page allocator top level: register port, request sequencer and state memories.
// One request at a time. Allocate scans the ranks upward for a non-empty free list, takes
// its head block, splits it down to the requested rank and marks it, writing the
// page-rank memory one page a cycle; free clears the block the same way and, per merge
// step, walks the free list of the rank for the buddy; a rank query of a free page
// scans page-rank entries. Each memory has a single read and a single write port.
// After reset and after each write of page_count a clearing pass zeroes the page-rank
// memory; no request is taken meanwhile. A finished result waits in an output register.
module buddy_page_allocator_top import bpa_pkg::*; #(
  parameter int PAGES = PAGES_DEF,
  parameter int RANKS = RANKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [4:0]  in_rank,
  input  logic [15:0] in_page_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [14:0] out_block_page,
  output logic [15:0] out_query_value
);

  localparam int AW = $clog2(PAGES);
  localparam int RW = $clog2(RANKS);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ASCAN, S_TAKE_RD, S_TAKE_CHK, S_SPLIT, S_MARK,
    S_RK_RD, S_RK_CHK, S_MERGE, S_PUSH, S_QKMAX, S_QSCAN_RD, S_QSCAN_CHK, S_FIN
  } state_t;

  function automatic logic [RW-1:0] ri(input logic [4:0] r);
    logic [4:0] t;
    t = r - 5'd1;
    return t[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] pg(input logic [16:0] x);
    logic [AW-1:0] a;
    a = '0;
    if (x < 17'(PAGES)) a = x[AW-1:0];
    return a;
  endfunction

  function automatic logic [16:0] sp(input logic [4:0] k);
    logic [4:0] s;
    s = k - 5'd1;
    return 17'd1 << s;
  endfunction

  function automatic logic [4:0] msb1(input logic [15:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) p = 5'(i + 1);
    end
    return p;
  endfunction

  function automatic logic [15:0] clampc(input logic [15:0] v);
    logic [15:0] c;
    c = v;
    if (v == 16'd0) c = 16'd1;
    if (17'(v) > 17'(PAGES)) c = 16'(PAGES);
    return c;
  endfunction

  function automatic logic [4:0] topr(input logic [15:0] c);
    logic [4:0] t;
    t = msb1(c);
    if (t > 5'(RANKS)) t = 5'(RANKS);
    return t;
  endfunction

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [15:0]   page_count_r, page_count_nxt;
  logic [4:0]    top_r, top_nxt;
  logic [15:0]   head_r [RANKS];
  logic [15:0]   head_nxt [RANKS];
  logic [15:0]   len_r [RANKS];
  logic [15:0]   len_nxt [RANKS];
  logic [1:0]    op_r, op_nxt;
  logic [4:0]    rank_r, rank_nxt;
  logic [15:0]   page_r, page_nxt;
  logic [4:0]    c_r, c_nxt;
  logic [4:0]    k_r, k_nxt;
  logic [4:0]    mrank_r, mrank_nxt;
  logic [4:0]    mval_r, mval_nxt;
  logic [15:0]   b_r, b_nxt;
  logic [15:0]   bud_r, bud_nxt;
  logic [15:0]   cur_r, cur_nxt;
  logic [15:0]   prev_r, prev_nxt;
  logic [15:0]   i_r, i_nxt;
  logic [15:0]   n_r, n_nxt;
  logic [15:0]   cnt_r, cnt_nxt;
  logic [15:0]   smax_r, smax_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [14:0]   blk_r, blk_nxt;
  logic [15:0]   qv_r, qv_nxt;
  logic          ov_r, ov_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [14:0]   oblk_r, oblk_nxt;
  logic [15:0]   oqv_r, oqv_nxt;

  logic          rk_we, lk_we;
  logic [AW-1:0] rk_waddr, rk_raddr, lk_waddr, lk_raddr;
  logic [4:0]    rk_wdata, rk_rdata;
  logic [15:0]   lk_wdata, lk_rdata;

  logic          cfg_we;
  logic [15:0]   cfg_cnt;
  logic [16:0]   s17, pg17;

  bpa_ram #(.W(5), .DEPTH(PAGES), .AW(AW)) u_rank_mem (
    .clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
    .raddr(rk_raddr), .rdata(rk_rdata)
  );

  bpa_ram #(.W(16), .DEPTH(PAGES), .AW(AW)) u_link_mem (
    .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
    .raddr(lk_raddr), .rdata(lk_rdata)
  );

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_PAGE_COUNT) ? {16'd0, page_count_r} : 32'd0;
  assign cfg_we   = psel && penable && pwrite && (paddr[2] == REG_PAGE_COUNT);
  assign cfg_cnt  = clampc(pwdata[15:0]);
  assign in_ready = (state_r == S_IDLE);
  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_block_page  = oblk_r;
  assign out_query_value = oqv_r;

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    page_count_nxt = page_count_r;
    top_nxt = top_r;
    head_nxt = head_r;
    len_nxt = len_r;
    op_nxt = op_r;
    rank_nxt = rank_r;
    page_nxt = page_r;
    c_nxt = c_r;
    k_nxt = k_r;
    mrank_nxt = mrank_r;
    mval_nxt = mval_r;
    b_nxt = b_r;
    bud_nxt = bud_r;
    cur_nxt = cur_r;
    prev_nxt = prev_r;
    i_nxt = i_r;
    n_nxt = n_r;
    cnt_nxt = cnt_r;
    smax_nxt = smax_r;
    st_nxt = st_r;
    blk_nxt = blk_r;
    qv_nxt = qv_r;
    ov_nxt = ov_r;
    ost_nxt = ost_r;
    oblk_nxt = oblk_r;
    oqv_nxt = oqv_r;
    rk_we = 1'b0;
    rk_waddr = '0;
    rk_wdata = '0;
    rk_raddr = pg({1'b0, page_r});
    lk_we = 1'b0;
    lk_waddr = '0;
    lk_wdata = '0;
    lk_raddr = pg({1'b0, cur_r});
    s17 = '0;
    pg17 = '0;

    if (ov_r && out_ready) ov_nxt = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        rk_we = 1'b1;
        rk_waddr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(PAGES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_operation;
          rank_nxt = in_rank;
          page_nxt = in_page_index;
          st_nxt = ST_OK;
          blk_nxt = '0;
          qv_nxt = '0;
          unique case (in_operation)
            OP_ALLOC: begin
              if (in_rank == 5'd0 || in_rank > 5'(RANKS)) begin
                st_nxt = ST_INVALID;
                state_nxt = S_FIN;
              end else begin
                c_nxt = in_rank;
                state_nxt = S_ASCAN;
              end
            end
            OP_FREE, OP_PRANK: begin
              if (in_page_index >= page_count_r) begin
                st_nxt = ST_INVALID;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_RK_RD;
              end
            end
            OP_COUNT: begin
              if (in_rank == 5'd0 || in_rank > 5'(RANKS)) st_nxt = ST_INVALID;
              else qv_nxt = len_r[ri(in_rank)];
              state_nxt = S_FIN;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_ASCAN: begin
        if (c_r > top_r) begin
          st_nxt = ST_NOSPACE;
          state_nxt = S_FIN;
        end else if (len_r[ri(c_r)] == 16'd0) begin
          c_nxt = c_r + 5'd1;
        end else begin
          b_nxt = head_r[ri(c_r)];
          bud_nxt = head_r[ri(c_r)];
          cur_nxt = head_r[ri(c_r)];
          prev_nxt = '0;
          i_nxt = '0;
          n_nxt = len_r[ri(c_r)];
          k_nxt = c_r;
          state_nxt = S_TAKE_RD;
        end
      end
      S_TAKE_RD: begin
        lk_raddr = pg({1'b0, cur_r});
        if (i_r == n_r) state_nxt = S_PUSH;
        else state_nxt = S_TAKE_CHK;
      end
      S_TAKE_CHK: begin
        if (cur_r == bud_r) begin
          if (i_r == 16'd0) begin
            head_nxt[ri(k_r)] = lk_rdata;
          end else begin
            lk_we = 1'b1;
            lk_waddr = pg({1'b0, prev_r});
            lk_wdata = lk_rdata;
          end
          len_nxt[ri(k_r)] = len_r[ri(k_r)] - 16'd1;
          if (op_r == OP_ALLOC) begin
            state_nxt = S_SPLIT;
          end else begin
            if (bud_r < b_r) b_nxt = bud_r;
            k_nxt = k_r + 5'd1;
            state_nxt = S_MERGE;
          end
        end else begin
          prev_nxt = cur_r;
          cur_nxt = lk_rdata;
          i_nxt = i_r + 16'd1;
          state_nxt = S_TAKE_RD;
        end
      end
      S_SPLIT: begin
        if (c_r > rank_r) begin
          pg17 = {1'b0, b_r} + sp(c_r - 5'd1);
          lk_we = 1'b1;
          lk_waddr = pg(pg17);
          lk_wdata = head_r[ri(c_r - 5'd1)];
          head_nxt[ri(c_r - 5'd1)] = pg17[15:0];
          len_nxt[ri(c_r - 5'd1)] = len_r[ri(c_r - 5'd1)] + 16'd1;
          c_nxt = c_r - 5'd1;
        end else begin
          mrank_nxt = rank_r;
          mval_nxt = rank_r;
          cnt_nxt = '0;
          blk_nxt = b_r[14:0];
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        rk_we = 1'b1;
        rk_waddr = pg({1'b0, b_r} + {1'b0, cnt_r});
        rk_wdata = mval_r;
        s17 = sp(mrank_r) - 17'd1;
        cnt_nxt = cnt_r + 16'd1;
        if ({1'b0, cnt_r} == s17) begin
          if (op_r == OP_ALLOC) state_nxt = S_FIN;
          else state_nxt = S_MERGE;
        end
      end
      S_RK_RD: begin
        rk_raddr = pg({1'b0, page_r});
        state_nxt = S_RK_CHK;
      end
      S_RK_CHK: begin
        if (op_r == OP_FREE) begin
          s17 = sp(rk_rdata) - 17'd1;
          if (rk_rdata == 5'd0 || (({1'b0, page_r}) & s17) != 17'd0) begin
            st_nxt = ST_INVALID;
            state_nxt = S_FIN;
          end else begin
            b_nxt = page_r;
            k_nxt = rk_rdata;
            mrank_nxt = rk_rdata;
            mval_nxt = '0;
            cnt_nxt = '0;
            state_nxt = S_MARK;
          end
        end else if (rk_rdata != 5'd0) begin
          qv_nxt = {11'd0, rk_rdata};
          state_nxt = S_FIN;
        end else begin
          k_nxt = top_r;
          state_nxt = S_QKMAX;
        end
      end
      S_MERGE: begin
        if (k_r < top_r) begin
          s17 = sp(k_r);
          bud_nxt = b_r ^ s17[15:0];
          cur_nxt = head_r[ri(k_r)];
          prev_nxt = '0;
          i_nxt = '0;
          n_nxt = len_r[ri(k_r)];
          state_nxt = S_TAKE_RD;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        lk_we = 1'b1;
        lk_waddr = pg({1'b0, b_r});
        lk_wdata = head_r[ri(k_r)];
        head_nxt[ri(k_r)] = b_r;
        len_nxt[ri(k_r)] = len_r[ri(k_r)] + 16'd1;
        state_nxt = S_FIN;
      end
      S_QKMAX: begin
        s17 = sp(k_r);
        if ((({1'b0, page_r}) & (s17 - 17'd1)) == 17'd0 &&
            ({1'b0, page_r} + s17) <= {1'b0, page_count_r}) begin
          smax_nxt = s17[15:0];
          cnt_nxt = 16'd1;
          state_nxt = S_QSCAN_RD;
        end else begin
          k_nxt = k_r - 5'd1;
        end
      end
      S_QSCAN_RD: begin
        rk_raddr = pg({1'b0, page_r} + {1'b0, cnt_r});
        if (cnt_r == smax_r) begin
          qv_nxt = {11'd0, msb1(cnt_r)};
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_QSCAN_CHK;
        end
      end
      S_QSCAN_CHK: begin
        if (rk_rdata != 5'd0) begin
          qv_nxt = {11'd0, msb1(cnt_r)};
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 16'd1;
          state_nxt = S_QSCAN_RD;
        end
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          ost_nxt = st_r;
          oblk_nxt = blk_r;
          oqv_nxt = (st_r == ST_OK) ? qv_r : 16'd0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      page_count_nxt = cfg_cnt;
      top_nxt = topr(cfg_cnt);
      for (int i = 0; i < RANKS; i++) begin
        head_nxt[i] = '0;
        len_nxt[i] = '0;
      end
      len_nxt[ri(topr(cfg_cnt))] = 16'd1;
      clr_nxt = '0;
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      page_count_r <= 16'(PAGES);
      top_r <= topr(16'(PAGES));
      for (int i = 0; i < RANKS; i++) begin
        head_r[i] <= '0;
        len_r[i] <= (RW'(i) == ri(topr(16'(PAGES)))) ? 16'd1 : 16'd0;
      end
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      page_count_r <= page_count_nxt;
      top_r <= top_nxt;
      head_r <= head_nxt;
      len_r <= len_nxt;
      ov_r <= ov_nxt;
    end
    op_r <= op_nxt;
    rank_r <= rank_nxt;
    page_r <= page_nxt;
    c_r <= c_nxt;
    k_r <= k_nxt;
    mrank_r <= mrank_nxt;
    mval_r <= mval_nxt;
    b_r <= b_nxt;
    bud_r <= bud_nxt;
    cur_r <= cur_nxt;
    prev_r <= prev_nxt;
    i_r <= i_nxt;
    n_r <= n_nxt;
    cnt_r <= cnt_nxt;
    smax_r <= smax_nxt;
    st_r <= st_nxt;
    blk_r <= blk_nxt;
    qv_r <= qv_nxt;
    ost_r <= ost_nxt;
    oblk_r <= oblk_nxt;
    oqv_r <= oqv_nxt;
  end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the buddy page allocator: directed table, then random traffic.
module tb_top import bpa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPAGES = 32768;
  localparam int NRANKS = 16;
  localparam int STALL_LIMIT = 400000;
  localparam int SETTLE = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] block_page;
    logic [15:0] query_value;
  } alloc_result_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [4:0]    rank;
    logic [15:0]   page;
    logic          typed;
    alloc_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_operation = '0;
  logic [4:0] in_rank = '0;
  logic [15:0] in_page_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [14:0] out_block_page;
  logic [15:0] out_query_value;

  buddy_page_allocator_top uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // allocator shadow state
  logic [4:0]  page_rank_sh[NPAGES];
  logic [15:0] link_sh[NPAGES];
  logic [15:0] head_sh[NRANKS];
  logic [15:0] len_sh[NRANKS];
  int pool_pages, top_rank_sh;

  alloc_result_t pending_results[$];
  logic [15:0] live_blocks[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  function automatic int idx(int p);
    return (p < NPAGES) ? p : 0;
  endfunction

  function automatic void list_push(int r, int page);
    link_sh[idx(page)] = head_sh[r-1];
    head_sh[r-1] = page[15:0];
    len_sh[r-1]++;
  endfunction

  function automatic void pool_reset(int count);
    int c;
    if (count < 1) count = 1;
    if (count > NPAGES) count = NPAGES;
    pool_pages = count;
    c = count;
    top_rank_sh = 1;
    while (c > 1) begin
      c = c >> 1;
      top_rank_sh++;
    end
    if (top_rank_sh > NRANKS) top_rank_sh = NRANKS;
    for (int i = 0; i < NPAGES; i++) begin
      page_rank_sh[i] = '0;
      link_sh[i] = '0;
    end
    for (int i = 0; i < NRANKS; i++) begin
      head_sh[i] = '0;
      len_sh[i] = '0;
    end
    list_push(top_rank_sh, 0);
  endfunction

  function automatic bit list_unlink(int r, int page);
    int cur, prev;
    cur = head_sh[r-1];
    prev = 0;
    for (int i = 0; i < len_sh[r-1]; i++) begin
      if (cur == page) begin
        if (i == 0) head_sh[r-1] = link_sh[idx(cur)];
        else link_sh[idx(prev)] = link_sh[idx(cur)];
        len_sh[r-1]--;
        return 1'b1;
      end
      prev = cur;
      cur = link_sh[idx(cur)];
    end
    return 1'b0;
  endfunction

  function automatic void mark_block(int first, int r, logic [4:0] v);
    for (int i = 0; i < (1 << (r-1)); i++) page_rank_sh[idx(first + i)] = v;
  endfunction

  function automatic alloc_result_t alloc_step(logic [1:0] op, logic [4:0] rk, logic [15:0] pi);
    alloc_result_t res;
    int r, c, b, k, bud, p, s;
    bit ok;
    res = '0;
    r = rk;
    p = pi;
    case (op)
      OP_ALLOC: begin
        if (r < 1 || r > NRANKS) res.status = ST_INVALID;
        else begin
          c = r;
          while (c <= top_rank_sh && len_sh[c-1] == 0) c++;
          if (c > top_rank_sh) res.status = ST_NOSPACE;
          else begin
            b = head_sh[c-1];
            void'(list_unlink(c, b));
            while (c > r) begin
              c--;
              list_push(c, b + (1 << (c-1)));
            end
            mark_block(b, r, r[4:0]);
            res.block_page = b[14:0];
          end
        end
      end
      OP_FREE: begin
        k = (p < pool_pages) ? page_rank_sh[idx(p)] : 0;
        if (k == 0 || (p & ((1 << (k-1)) - 1)) != 0) res.status = ST_INVALID;
        else begin
          b = p;
          mark_block(b, k, '0);
          while (k < top_rank_sh) begin
            bud = b ^ (1 << (k-1));
            if (!list_unlink(k, bud)) break;
            if (bud < b) b = bud;
            k++;
          end
          list_push(k, b);
        end
      end
      OP_PRANK: begin
        if (p >= pool_pages) res.status = ST_INVALID;
        else if (page_rank_sh[idx(p)] != 0) res.query_value = page_rank_sh[idx(p)];
        else begin
          for (k = top_rank_sh; k >= 1; k--) begin
            s = 1 << (k-1);
            ok = ((p & (s-1)) == 0) && (p + s <= pool_pages);
            for (int i = 0; ok && i < s; i++)
              if (page_rank_sh[idx(p + i)] != 0) ok = 1'b0;
            if (ok) begin
              res.query_value = k[15:0];
              break;
            end
          end
          if (res.query_value == 0) res.status = ST_INVALID;
        end
      end
      default: begin
        if (r < 1 || r > NRANKS) res.status = ST_INVALID;
        else res.query_value = len_sh[r-1];
      end
    endcase
    return res;
  endfunction

  function automatic bit draw_idle();
    return !calm && ($urandom_range(99) < 37);
  endfunction

  task automatic send_request(logic [1:0] op, logic [4:0] rk, logic [15:0] pi,
                              bit typed, alloc_result_t typed_res);
    int gap;
    alloc_result_t res;
    gap = draw_idle() ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_rank <= rk;
    in_page_index <= pi;
    do @(posedge clk); while (!in_ready);
    res = alloc_step(op, rk, pi);
    if (op == OP_ALLOC && res.status == ST_OK) live_blocks.push_back({1'b0, res.block_page});
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic write_page_count(logic [31:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * REG_PAGE_COUNT);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pool_reset(value[15:0]);
    live_blocks.delete();
  endtask

  task automatic random_request(bit big);
    int sel, j;
    logic [4:0] rk;
    logic [15:0] pi;
    sel = $urandom_range(99);
    rk = 5'($urandom_range(1, big ? 6 : top_rank_sh));
    pi = 16'($urandom_range(0, pool_pages + 2));
    if ($urandom_range(99) < 5) pi = 16'($urandom_range(0, 65535));
    if (sel < 40) begin
      if ($urandom_range(99) < 10)
        rk = big ? 5'($urandom_range(17, 31)) * 5'($urandom_range(0, 1))
                 : 5'($urandom_range(0, 31));
      send_request(OP_ALLOC, rk, pi, 1'b0, '0);
    end else if (sel < 70) begin
      if (live_blocks.size() != 0 && $urandom_range(99) < 85) begin
        j = $urandom_range(0, live_blocks.size() - 1);
        pi = live_blocks[j];
        live_blocks.delete(j);
      end
      send_request(OP_FREE, rk, pi, 1'b0, '0);
    end else if (sel < 85 && !(big && live_blocks.size() == 0)) begin
      if (big) pi = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
      send_request(OP_PRANK, rk, pi, 1'b0, '0);
    end else begin
      send_request(OP_COUNT, 5'($urandom_range(0, 31)), pi, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_status);
          errors++;
        end
        if (out_block_page !== want.block_page) begin
          $error("block_page: expected %0d actual %0d", want.block_page, out_block_page);
          errors++;
        end
        if (out_query_value !== want.query_value) begin
          $error("query_value: expected %0d actual %0d", want.query_value, out_query_value);
          errors++;
        end
      end
    end
    out_ready <= !draw_idle();
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("buddy_page_allocator_top regression: fail");
      $finish;
    end
  end

  dir_row_t dir_rows[21];
  int phase_pages[9] = '{64, 100, 1, 0, 2, 13, 1024, 65535, 40000};

  initial begin
    dir_rows[0]  = '{OP_COUNT, 5'd16, 16'd0,     1'b1, '{ST_OK, 15'd0, 16'd1}};
    dir_rows[1]  = '{OP_COUNT, 5'd0,  16'd0,     1'b1, '{ST_INVALID, 15'd0, 16'd0}};
    dir_rows[2]  = '{OP_COUNT, 5'd31, 16'd0,     1'b1, '{ST_INVALID, 15'd0, 16'd0}};
    dir_rows[3]  = '{OP_ALLOC, 5'd0,  16'd0,     1'b1, '{ST_INVALID, 15'd0, 16'd0}};
    dir_rows[4]  = '{OP_ALLOC, 5'd17, 16'd0,     1'b1, '{ST_INVALID, 15'd0, 16'd0}};
    dir_rows[5]  = '{OP_FREE,  5'd1,  16'd0,     1'b1, '{ST_INVALID, 15'd0, 16'd0}};
    dir_rows[6]  = '{OP_PRANK, 5'd1,  16'hFFFF,  1'b1, '{ST_INVALID, 15'd0, 16'd0}};
    dir_rows[7]  = '{OP_ALLOC, 5'd1,  16'd0,     1'b1, '{ST_OK, 15'd0, 16'd0}};
    dir_rows[8]  = '{OP_PRANK, 5'd1,  16'd0,     1'b1, '{ST_OK, 15'd0, 16'd1}};
    dir_rows[9]  = '{OP_PRANK, 5'd1,  16'd1,     1'b0, '0};
    dir_rows[10] = '{OP_FREE,  5'd1,  16'd1,     1'b1, '{ST_INVALID, 15'd0, 16'd0}};
    dir_rows[11] = '{OP_ALLOC, 5'd2,  16'd0,     1'b0, '0};
    dir_rows[12] = '{OP_FREE,  5'd1,  16'd3,     1'b1, '{ST_INVALID, 15'd0, 16'd0}};
    dir_rows[13] = '{OP_FREE,  5'd1,  16'd0,     1'b1, '{ST_OK, 15'd0, 16'd0}};
    dir_rows[14] = '{OP_FREE,  5'd1,  16'd2,     1'b0, '0};
    dir_rows[15] = '{OP_COUNT, 5'd16, 16'd0,     1'b0, '0};
    dir_rows[16] = '{OP_ALLOC, 5'd16, 16'd0,     1'b1, '{ST_OK, 15'd0, 16'd0}};
    dir_rows[17] = '{OP_ALLOC, 5'd1,  16'd0,     1'b1, '{ST_NOSPACE, 15'd0, 16'd0}};
    dir_rows[18] = '{OP_PRANK, 5'd1,  16'd32767, 1'b0, '0};
    dir_rows[19] = '{OP_FREE,  5'd1,  16'd0,     1'b1, '{ST_OK, 15'd0, 16'd0}};
    dir_rows[20] = '{OP_COUNT, 5'd1,  16'd0,     1'b0, '0};
    pool_reset(32768);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i])
      send_request(dir_rows[i].op, dir_rows[i].rank, dir_rows[i].page,
                   dir_rows[i].typed, dir_rows[i].res);
    live_blocks.delete();
    foreach (phase_pages[ph]) begin
      write_page_count(phase_pages[ph]);
      calm = (ph == 5);
      for (int n = 0; n < 110; n++) random_request(pool_pages > 4096);
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("buddy_page_allocator_top regression: pass");
    end else begin
      $display("buddy_page_allocator_top regression: fail");
    end
    $finish;
  end

endmodule
